// ----- rtl/core/skf_pkg.sv -----
// Shared types, constants and microcode program of the scalar Kalman filter.
package skf_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned NOISE_W = 31;
  localparam int unsigned GAIN_W = 17;
  localparam int unsigned DIFF_W = 33;
  localparam int unsigned DEN_W = 33;
  localparam int unsigned REM_W = 34;
  localparam int unsigned MUL_W = 18;
  localparam int unsigned PROD_W = 36;
  localparam int unsigned ACC_W = 52;
  localparam int unsigned STEP_W = 4;
  localparam int unsigned CNT_W = 5;
  localparam int unsigned ADDR_W = 4;

  localparam logic [GAIN_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [CNT_W-1:0] DIV_STEPS = 5'd17;
  localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST = 31'd66;
  localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RST = 31'd65536;
  localparam logic [DATA_W-1:0] INITIAL_ESTIMATE_RST = 32'd0;
  localparam logic [NOISE_W-1:0] INITIAL_COVARIANCE_RST = 31'd65536;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [1:0] REG_MEASUREMENT_NOISE = 2'd1;
  localparam logic [1:0] REG_INITIAL_ESTIMATE = 2'd2;
  localparam logic [1:0] REG_INITIAL_COVARIANCE = 2'd3;

  // program steps
  localparam logic [STEP_W-1:0] ST_WAIT_IN = 4'd0;
  localparam logic [STEP_W-1:0] ST_PREP = 4'd1;
  localparam logic [STEP_W-1:0] ST_DIV_INIT = 4'd2;
  localparam logic [STEP_W-1:0] ST_DIV = 4'd3;
  localparam logic [STEP_W-1:0] ST_MUL_GD_LO = 4'd4;
  localparam logic [STEP_W-1:0] ST_MUL_GD_HI = 4'd5;
  localparam logic [STEP_W-1:0] ST_ADD_GD = 4'd6;
  localparam logic [STEP_W-1:0] ST_UPD_X = 4'd7;
  localparam logic [STEP_W-1:0] ST_ADD_KP = 4'd8;
  localparam logic [STEP_W-1:0] ST_FINISH = 4'd9;

  typedef enum logic [1:0] {
    MUL_GD_LO,
    MUL_GD_HI,
    MUL_KP_LO,
    MUL_KP_HI
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD_HI
  } acc_op_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_LOOP_DIV,
    SEQ_RESTART
  } seq_t;

  typedef struct packed {
    logic     wait_in;
    logic     ld_prep;
    logic     ld_div;
    logic     div_step;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     ld_x;
    logic     ld_p;
    logic     wait_out;
    seq_t     seq;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    wait_in: 1'b0, ld_prep: 1'b0, ld_div: 1'b0, div_step: 1'b0,
    mul_sel: MUL_GD_LO, acc_op: ACC_HOLD, ld_x: 1'b0, ld_p: 1'b0,
    wait_out: 1'b0, seq: SEQ_NEXT
  };

  // Control store: one word per program step.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] pc);
    ctrl_t c;
    c = CTRL_NOP;
    unique case (pc)
      ST_WAIT_IN: c.wait_in = 1'b1;
      ST_PREP: c.ld_prep = 1'b1;
      ST_DIV_INIT: c.ld_div = 1'b1;
      ST_DIV: begin
        c.div_step = 1'b1;
        c.seq = SEQ_LOOP_DIV;
      end
      ST_MUL_GD_LO: c.mul_sel = MUL_GD_LO;
      ST_MUL_GD_HI: begin
        c.mul_sel = MUL_GD_HI;
        c.acc_op = ACC_LOAD;
      end
      ST_ADD_GD: begin
        c.mul_sel = MUL_KP_LO;
        c.acc_op = ACC_ADD_HI;
      end
      ST_UPD_X: begin
        c.ld_x = 1'b1;
        c.mul_sel = MUL_KP_HI;
        c.acc_op = ACC_LOAD;
      end
      ST_ADD_KP: c.acc_op = ACC_ADD_HI;
      ST_FINISH: begin
        c.ld_p = 1'b1;
        c.wait_out = 1'b1;
        c.seq = SEQ_RESTART;
      end
      default: c.seq = SEQ_RESTART;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/scalar_kalman_filter.sv -----
// Scalar Kalman filter top level: APB registers, microcode sequencer and datapath.
// A measurement is taken only at the input wait step, so the next item waits until
// the program, with its restoring gain divider, has run through the previous one.
// A finished estimate waits in the output register while the next item is taken.
// Reset (rst, synchronous, active high) restores register defaults, estimate 0
// and covariance 1.0, and parks the sequencer at the input wait step.
module scalar_kalman_filter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [skf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [31:0]         measurement,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         filtered_value
);
  import skf_pkg::*;

  // configuration registers
  logic [NOISE_W-1:0] process_noise;
  logic [NOISE_W-1:0] measurement_noise;
  logic [DATA_W-1:0]  initial_estimate;
  logic [NOISE_W-1:0] initial_covariance;

  // filter state
  logic signed [DATA_W-1:0] estimate;
  logic [DATA_W-1:0]        covariance;

  // sequencer
  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  ctrl_t             ctrl;
  logic [CNT_W-1:0]  div_cnt;

  // datapath registers
  logic signed [DATA_W-1:0] z;
  logic signed [DIFF_W-1:0] d;
  logic [DATA_W-1:0]        p1;
  logic [DEN_W-1:0]         den;
  logic                     den_zero;
  logic [REM_W-1:0]         rem;
  logic [GAIN_W-1:0]        quot;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  // combinational datapath
  logic                     cfg_wr;
  logic                     out_free;
  logic                     hold;
  logic [DEN_W-1:0]         p1_sum;
  logic [DATA_W-1:0]        p1_sat;
  logic [DEN_W-1:0]         den_sum;
  logic                     div_ge;
  logic [REM_W-1:0]         div_diff;
  logic [DEN_W-1:0]         rem_kept;
  logic [GAIN_W-1:0]        gain;
  logic [GAIN_W-1:0]        one_minus_k;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] x_step;
  logic signed [DATA_W+4:0] x_sum;
  logic signed [DATA_W-1:0] x_sat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_PROCESS_NOISE:      prdata = {1'b0, process_noise};
      REG_MEASUREMENT_NOISE:  prdata = {1'b0, measurement_noise};
      REG_INITIAL_ESTIMATE:   prdata = initial_estimate;
      REG_INITIAL_COVARIANCE: prdata = {1'b0, initial_covariance};
      default:                prdata = '0;
    endcase
  end

  // fetch the control word of the current step
  assign ctrl = ucode(pc);
  assign in_ready = ctrl.wait_in;
  assign out_free = !out_valid || out_ready;

  // hold the step while waiting on a port or while the divider loops
  assign hold = (ctrl.wait_in && !in_valid) ||
                (ctrl.wait_out && !out_free) ||
                (ctrl.seq == SEQ_LOOP_DIV && div_cnt != 5'd1);

  always_comb begin
    if (hold) begin
      pc_next = pc;
    end else if (ctrl.seq == SEQ_RESTART) begin
      pc_next = ST_WAIT_IN;
    end else begin
      pc_next = pc + 4'd1;
    end
  end

  // predicted covariance, saturated at all ones
  assign p1_sum = {1'b0, covariance} + {2'b00, process_noise};
  assign p1_sat = p1_sum[DEN_W-1] ? '1 : p1_sum[DATA_W-1:0];
  assign den_sum = {1'b0, p1} + {2'b00, measurement_noise};

  // one restoring division step: quotient bit from compare, shift remainder
  assign div_ge = rem >= {1'b0, den};
  assign div_diff = rem - {1'b0, den};
  assign rem_kept = div_ge ? div_diff[DEN_W-1:0] : rem[DEN_W-1:0];

  // a zero denominator forces zero gain
  assign gain = den_zero ? '0 : quot;
  assign one_minus_k = ONE_Q16 - gain;

  // shared 18x18 signed multiplier, operands picked by the control word
  always_comb begin
    unique case (ctrl.mul_sel)
      MUL_GD_LO: begin
        mul_a = {1'b0, gain};
        mul_b = {2'b00, d[15:0]};
      end
      MUL_GD_HI: begin
        mul_a = {1'b0, gain};
        mul_b = {d[DIFF_W-1], d[DIFF_W-1:16]};
      end
      MUL_KP_LO: begin
        mul_a = {1'b0, one_minus_k};
        mul_b = {2'b00, p1[15:0]};
      end
      MUL_KP_HI: begin
        mul_a = {1'b0, one_minus_k};
        mul_b = {2'b00, p1[31:16]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // floor(K*d / 2^16) is an arithmetic shift; saturate the new estimate
  assign x_step = acc[ACC_W-1:16];
  assign x_sum = {{5{estimate[DATA_W-1]}}, estimate} + {x_step[PROD_W-1], x_step};
  always_comb begin
    if (x_sum[DATA_W+4:DATA_W-1] == '0 || x_sum[DATA_W+4:DATA_W-1] == '1) begin
      x_sat = x_sum[DATA_W-1:0];
    end else if (x_sum[DATA_W+4]) begin
      x_sat = 32'sh8000_0000;
    end else begin
      x_sat = 32'sh7FFF_FFFF;
    end
  end

  // control, configuration and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_WAIT_IN;
      out_valid <= 1'b0;
      div_cnt <= '0;
      process_noise <= PROCESS_NOISE_RST;
      measurement_noise <= MEASUREMENT_NOISE_RST;
      initial_estimate <= INITIAL_ESTIMATE_RST;
      initial_covariance <= INITIAL_COVARIANCE_RST;
      estimate <= INITIAL_ESTIMATE_RST;
      covariance <= {1'b0, INITIAL_COVARIANCE_RST};
    end else begin
      pc <= pc_next;

      if (ctrl.ld_div) begin
        div_cnt <= DIV_STEPS;
      end else if (ctrl.div_step) begin
        div_cnt <= div_cnt - 5'd1;
      end

      if (ctrl.ld_x) begin
        estimate <= x_sat;
      end
      if (ctrl.ld_p) begin
        covariance <= acc[47:16];
      end

      // load the result when the output register is free, else drop it once taken
      if (ctrl.wait_out && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // writes must arrive only while idle (unenforced); an initial register also seeds the state
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_PROCESS_NOISE:     process_noise <= pwdata[NOISE_W-1:0];
          REG_MEASUREMENT_NOISE: measurement_noise <= pwdata[NOISE_W-1:0];
          REG_INITIAL_ESTIMATE: begin
            initial_estimate <= pwdata;
            estimate <= pwdata;
          end
          REG_INITIAL_COVARIANCE: begin
            initial_covariance <= pwdata[NOISE_W-1:0];
            covariance <= {1'b0, pwdata[NOISE_W-1:0]};
          end
          default: ;
        endcase
      end
    end
  end

  // datapath payload registers
  always_ff @(posedge clk) begin
    if (ctrl.wait_in && in_valid) begin
      z <= measurement;
    end
    if (ctrl.ld_prep) begin
      p1 <= p1_sat;
      d <= {z[DATA_W-1], z} - {estimate[DATA_W-1], estimate};
    end
    if (ctrl.ld_div) begin
      den <= den_sum;
      den_zero <= den_sum == '0;
      rem <= {2'b00, p1};
      quot <= '0;
    end
    if (ctrl.div_step) begin
      rem <= {rem_kept, 1'b0};
      quot <= {quot[GAIN_W-2:0], div_ge};
    end

    prod <= mul_a * mul_b;

    unique case (ctrl.acc_op)
      ACC_HOLD:   acc <= acc;
      ACC_LOAD:   acc <= {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
      ACC_ADD_HI: acc <= acc + {prod, 16'h0000};
      default:    acc <= acc;
    endcase

    if (ctrl.wait_out && out_free) begin
      filtered_value <= estimate;
    end
  end

  // an accepted item always starts the update program
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> pc == ST_PREP)
    else $error("accepted item did not start the program");

  // the divider loop never runs with an exhausted count
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    pc == ST_DIV |-> div_cnt != '0 && div_cnt <= DIV_STEPS)
    else $error("divider count out of range");

  // the gain leaving the divider never exceeds 1.0
  a_gain_max: assert property (@(posedge clk) disable iff (rst)
    pc == ST_MUL_GD_LO |-> gain <= ONE_Q16)
    else $error("gain above one");

  // the new covariance is non-negative and fits 32 bits before it is stored
  a_cov_fits: assert property (@(posedge clk) disable iff (rst)
    pc == ST_FINISH |-> acc[ACC_W-1:48] == '0)
    else $error("covariance product out of range");

endmodule

// ----- test/tb_scalar_kalman_filter.sv -----
// Self-checking testbench for the scalar Kalman filter: APB setup, sample stream, estimate check.
module tb_scalar_kalman_filter;
  import skf_pkg::*;

  // Fixed-point bounds of the estimate and covariance arithmetic.
  localparam longint COV_CEILING = 64'h0000_0000_FFFF_FFFF;
  localparam longint EST_MAX = 64'sd2147483647;
  localparam longint EST_MIN = -64'sd2147483648;
  localparam int unsigned RANDOM_SAMPLES = 1250;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  // Extra time at the end for the last estimate to come out.
  localparam int unsigned DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // APB side
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // sample stream in, estimate stream out
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] measurement = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] filtered_value;

  // Filter model: register copies and running state.
  logic [NOISE_W-1:0] cfg_process_noise = PROCESS_NOISE_RST;
  logic [NOISE_W-1:0] cfg_measurement_noise = MEASUREMENT_NOISE_RST;
  logic [DATA_W-1:0] cfg_initial_estimate = INITIAL_ESTIMATE_RST;
  logic [NOISE_W-1:0] cfg_initial_covariance = INITIAL_COVARIANCE_RST;
  logic signed [31:0] est_state = INITIAL_ESTIMATE_RST;
  logic [31:0] cov_state = {1'b0, INITIAL_COVARIANCE_RST};

  // Samples waiting to be offered and estimates waiting to come out.
  logic [31:0] pending_samples[$];
  logic signed [31:0] expected_estimates[$];

  // Sender and receiver pacing, set per phase while the block is idle.
  int unsigned sender_max_gap = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic [15:0] receiver_pattern = 16'hFFFF;
  logic [3:0] stall_phase = '0;
  int unsigned holdoff_requests = 0;
  int unsigned holdoff_served = 0;
  int unsigned holdoff_left = 0;

  int unsigned error_count = 0;
  int unsigned samples_sent = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used = 0;
  logic signed [31:0] wanted_estimate;

  scalar_kalman_filter dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .measurement   (measurement),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .filtered_value(filtered_value)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Run one filter step on the model and return the new estimate.
  // Gain is P1/(P1+R) in Q1.16, the correction is floored, and the
  // covariance shrinks by (1-K).
  function automatic logic signed [31:0] kalman_update(input logic signed [31:0] z);
    longint p1;
    longint denom;
    longint gain;
    longint next_est;
    longint next_cov;
    p1 = {32'd0, cov_state} + {33'd0, cfg_process_noise};
    // covariance plus process noise saturates at all ones
    if (p1 > COV_CEILING) p1 = COV_CEILING;
    denom = p1 + {33'd0, cfg_measurement_noise};
    // zero denominator: no gain, estimate and covariance hold
    gain = (denom == 0) ? 0 : (p1 <<< 16) / denom;
    // arithmetic shift of the signed product floors toward minus infinity
    next_est = longint'(est_state) + ((gain * (longint'(z) - longint'(est_state))) >>> 16);
    if (next_est > EST_MAX) next_est = EST_MAX;
    if (next_est < EST_MIN) next_est = EST_MIN;
    est_state = next_est[31:0];
    next_cov = ((longint'(ONE_Q16) - gain) * p1) >>> 16;
    cov_state = next_cov[31:0];
    return est_state;
  endfunction

  // Noise register value: zero, the maximum, an all-ones word that the block
  // must mask, small and medium variances, or any word at all.
  function automatic logic [31:0] draw_noise();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(1, 32'h0001_0000);
      4: return $urandom_range(1, 32'h0040_0000);
      default: return $urandom;
    endcase
  endfunction

  // Sample around a center with a noise band of the given width, with some
  // wild samples and extremes mixed in.
  function automatic logic [31:0] draw_sample(input logic [31:0] center,
                                               input int unsigned spread_bits);
    logic [31:0] mask;
    logic [31:0] offset;
    mask = (32'd1 << spread_bits) - 32'd1;
    offset = ($urandom & mask) - (mask >> 1);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return center + offset;
    endcase
  endfunction

  // Write one register over APB: setup cycle, then access cycle.
  // Mirror the write into the model, including the state load.
  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PROCESS_NOISE: cfg_process_noise = value[NOISE_W-1:0];
      REG_MEASUREMENT_NOISE: cfg_measurement_noise = value[NOISE_W-1:0];
      REG_INITIAL_ESTIMATE: begin
        cfg_initial_estimate = value;
        est_state = value;
      end
      REG_INITIAL_COVARIANCE: begin
        cfg_initial_covariance = value[NOISE_W-1:0];
        cov_state = {1'b0, value[NOISE_W-1:0]};
      end
      default: ;
    endcase
  endtask

  // Hold until every queued sample went in and every estimate came out.
  // Look between rising edges so the sender's queue and in_valid agree.
  task automatic wait_until_idle();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_estimates.size() != 0);
  endtask

  // Set pacing for a phase, optionally ask the receiver for a long hold-off,
  // then let the queued samples run through.
  task automatic run_phase(input int unsigned max_gap, input logic [15:0] ready_pattern,
                           input bit long_holdoff);
    sender_max_gap = max_gap;
    receiver_pattern = (ready_pattern == 16'h0) ? 16'h0001 : ready_pattern;
    if (long_holdoff) holdoff_requests++;
    settings_used++;
    wait_until_idle();
  endtask

  // Sender: offer queued samples in bursts with gaps between them. Hold the
  // item steady while the block stalls; predict the estimate on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      measurement <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_estimates.push_back(kalman_update(measurement));
        samples_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_valid <= 1'b1;
          measurement <= pending_samples.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = (sender_max_gap == 0) ? 0 : $urandom_range(0, sender_max_gap);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each estimate against the oldest prediction. Stall on a
  // rotating pattern; on request hold off for a long stretch so the block
  // backs up into its input.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_phase <= '0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_estimates.size() == 0) begin
          $display("%0t: filtered_value %0d arrived with no estimate pending",
                   $time, filtered_value);
          error_count++;
        end else begin
          wanted_estimate = expected_estimates.pop_front();
          if (filtered_value !== wanted_estimate) begin
            $display("%0t: filtered_value mismatch: expected %0d (%h), actual %0d (%h)",
                     $time, wanted_estimate, wanted_estimate, filtered_value, filtered_value);
            error_count++;
          end
        end
      end
      if (holdoff_served != holdoff_requests) begin
        holdoff_served++;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= receiver_pattern[stall_phase];
        stall_phase <= stall_phase + 4'd1;
      end
    end
  end

  // Stimulus: directed corners first, then random phases with fresh settings.
  initial begin
    int unsigned random_items;
    int unsigned phase_index;
    int unsigned count;
    int unsigned spread;
    logic [31:0] center;
    random_items = 0;
    phase_index = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: extremes of the sample range.
    pending_samples.push_back(32'h7FFF_FFFF);
    pending_samples.push_back(32'h8000_0000);
    pending_samples.push_back(32'h0000_0000);
    pending_samples.push_back(32'hFFFF_FFFF);
    pending_samples.push_back(32'h0000_0001);
    pending_samples.push_back(32'h0001_0000);
    pending_samples.push_back(32'hFFFF_0000);
    run_phase(0, 16'hFFFF, 1'b0);

    // Zero measurement noise: gain is exactly one, estimate jumps to the sample.
    write_register(REG_MEASUREMENT_NOISE, 32'd0);
    pending_samples.push_back(32'h1234_5678);
    pending_samples.push_back(32'h8000_0000);
    pending_samples.push_back(32'h7FFF_FFFF);
    run_phase(3, 16'hB6DB, 1'b0);

    // Zero denominator: no noise at all and zero covariance, nothing moves.
    write_register(REG_PROCESS_NOISE, 32'd0);
    write_register(REG_INITIAL_COVARIANCE, 32'd0);
    pending_samples.push_back(32'h7FFF_FFFF);
    pending_samples.push_back(32'h8000_0000);
    run_phase(0, 16'hFFFF, 1'b0);

    // Maximum noise with all-ones writes (upper bit masked off), estimate at
    // the negative end and samples at the positive end: covariance runs near
    // its ceiling and the correction is as large as it gets.
    write_register(REG_MEASUREMENT_NOISE, 32'hFFFF_FFFF);
    write_register(REG_PROCESS_NOISE, 32'hFFFF_FFFF);
    write_register(REG_INITIAL_COVARIANCE, 32'hFFFF_FFFF);
    write_register(REG_INITIAL_ESTIMATE, 32'h8000_0000);
    repeat (6) pending_samples.push_back(32'h7FFF_FFFF);
    run_phase(8, 16'h5A5A, 1'b0);

    // Full gain from the positive end to the negative end of the range.
    write_register(REG_INITIAL_ESTIMATE, 32'h7FFF_FFFF);
    write_register(REG_MEASUREMENT_NOISE, 32'd0);
    write_register(REG_PROCESS_NOISE, 32'd1);
    write_register(REG_INITIAL_COVARIANCE, 32'd0);
    pending_samples.push_back(32'h8000_0000);
    pending_samples.push_back(32'h7FFF_FFFF);
    run_phase(0, 16'hFFFF, 1'b0);

    // Random phases: new settings each time, samples scattered around a
    // drifting center so the filter actually tracks something.
    while (random_items < RANDOM_SAMPLES) begin
      if ($urandom_range(0, 1)) write_register(REG_PROCESS_NOISE, draw_noise());
      if ($urandom_range(0, 1)) write_register(REG_MEASUREMENT_NOISE, draw_noise());
      center = $urandom;
      if ($urandom_range(0, 2) == 0) write_register(REG_INITIAL_ESTIMATE, $urandom);
      if ($urandom_range(0, 2) == 0) write_register(REG_INITIAL_COVARIANCE, draw_noise());
      count = $urandom_range(60, 120);
      spread = $urandom_range(4, 31);
      repeat (count) pending_samples.push_back(draw_sample(center, spread));
      random_items += count;
      case (phase_index % 3)
        0: run_phase(0, 16'hFFFF, phase_index % 4 == 1);
        1: run_phase(6, 16'($urandom), phase_index % 4 == 1);
        default: run_phase(40, 16'($urandom & $urandom), phase_index % 4 == 1);
      endcase
      phase_index++;
    end

    // Let any late output show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Filtered %0d samples over %0d register settings; %0d estimates compared.",
             samples_sent, settings_used, results_checked);
    $display("Receiver held off %0d times for %0d cycles with the sender still offering.",
             holdoff_served, HOLDOFF_CYCLES);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Timed out with %0d estimates still pending.", expected_estimates.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/skf_pkg.sv
rtl/core/scalar_kalman_filter.sv
test/tb_scalar_kalman_filter.sv
